FILE: sv/bia_pkg.sv
// Shared types, sizes and codes for the bounded integer array engine.
// No dependencies; every other file of the block but bia_ram imports this package.
package bia_pkg;

  // Store depth and the widths that follow from it.
  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);

  // Fixed field widths of the stream payloads.
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 16;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 10;
  localparam int CLEN_W = 11;

  // Packed payload widths and the byte-padded bus widths.
  localparam int IN_BITS  = CMD_W + POS_W + WORD_W;
  localparam int OUT_BITS = STAT_W + WORD_W + FIDX_W + CLEN_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Command codes; code 7 is unused and answers ok.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_PUSH   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_SORT   = 3'd5,
    CMD_RESIZE = 3'd6
  } cmd_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BAD_ALLOC = 2'd2,
    ST_NOT_FOUND = 2'd3
  } stat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_FIND,
    S_SORT_HEAD,
    S_SORT_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_RESULT
  } state_t;

  // Input beat, first field in the lowest bits.
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  position;
    cmd_t              cmd;
  } in_t;

  // Output beat, first field in the lowest bits.
  typedef struct packed {
    logic [CLEN_W-1:0] current_length;
    logic [FIDX_W-1:0] found_index;
    logic [WORD_W-1:0] read_value;
    stat_t             status;
  } out_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic vld;
    out_t data;
  } res_t;

  // Store write port.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } wr_t;

  // Outcome of the shared word comparator.
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

FILE: sv/bounded_int_array_engine.sv
// Bounded integer array engine: a store of DEPTH (1024) signed 32-bit words
// with a current length, driven by set, get, push, pop, find, sort and resize
// commands, one result beat per command beat. After reset the block zeroes
// the store one word a cycle and accepts no command until every word is cleared.
// Commands run one at a time through a single-port-read, single-port-write
// store and one shared comparator; find walks the words from index 0 to the
// first match and sort is a selection sort. The result sits in an output
// register, so a new command is taken while it waits.
// Depends on bia_pkg, bia_seq, bia_ram and bia_cmp.
module bounded_int_array_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // s_tdata, lowest bit up: cmd[3], position[16], value[32], zero fill
  input  logic [bia_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // m_tdata, lowest bit up: status[2], read_value[32], found_index[10],
  // current_length[11], zero fill
  output logic [bia_pkg::OUT_W-1:0] m_tdata
);
  import bia_pkg::*;

  in_t               item;
  res_t              res;
  wr_t               wr;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;
  logic              out_free;
  out_t              out_reg;

  assign item     = in_t'(s_tdata[IN_BITS-1:0]);
  assign out_free = !m_tvalid || m_tready;

  // Command sequencer with the shared comparator.
  bia_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .item     (item),
    .in_ready (s_tready),
    .out_free (out_free),
    .res      (res),
    .wr       (wr),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  // Element store.
  bia_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.vld && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res.vld && out_free) begin
      out_reg <= res.data;
    end
  end

  assign m_tdata = OUT_W'(out_reg);

`ifndef ASSERT_OFF
  // One command at a time: an accepted beat closes the input side.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a command is in progress");

  // A reported length never exceeds the store depth.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[OUT_BITS-1:OUT_BITS-CLEN_W]) <= 32'(DEPTH)))
    else $error("reported length exceeds the store depth");

  // A new output beat only appears after the sequencer offered a result.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(res.vld))
    else $error("output beat without a finished result");

  // The sequencer holds no result while the input side is open.
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !res.vld)
    else $error("result pending while accepting a command");
`endif

endmodule

FILE: sv/bia_cmp.sv
// Shared word comparator used by find (equality) and sort (signed less-than).
// Depends on bia_pkg for the word width and the result struct.
module bia_cmp (
  input  logic [bia_pkg::WORD_W-1:0] a,
  input  logic [bia_pkg::WORD_W-1:0] b,
  output bia_pkg::cmp_t              res
);
  import bia_pkg::*;

  // Equality for find, two's complement order for sort.
  always_comb begin
    res.eq = (a == b);
    res.lt = ($signed(a) < $signed(b));
  end

endmodule

FILE: sv/bia_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package dependency.
module bia_ram #(
  parameter int DEPTH_P = 1024,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH_P-1:0]         wdata,
  input  logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, data valid in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bia_seq.sv
// Command sequencer: decodes each command, walks the store for find and sort,
// and drives the store ports. Depends on bia_pkg and the bia_cmp comparator.
module bia_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  bia_pkg::in_t               item,
  output logic                       in_ready,
  input  logic                       out_free,
  output bia_pkg::res_t              res,
  output bia_pkg::wr_t               wr,
  output logic [bia_pkg::IDX_W-1:0]  raddr,
  input  logic [bia_pkg::WORD_W-1:0] rdata
);
  import bia_pkg::*;

  state_t            state, state_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [IDX_W-1:0]  clr, clr_next;
  logic [IDX_W-1:0]  i_idx, i_idx_next;
  logic [IDX_W-1:0]  j_idx, j_idx_next;
  logic [IDX_W-1:0]  pick, pick_next;
  logic [WORD_W-1:0] key, key_next;
  logic [WORD_W-1:0] head, head_next;
  stat_t             r_status, r_status_next;
  logic [WORD_W-1:0] r_read, r_read_next;
  logic [FIDX_W-1:0] r_found, r_found_next;
  cmp_t              cmp;
  logic              in_range;
  logic              j_last;
  logic              i_done;

  // The one compare unit: the word just read against the key register.
  bia_cmp u_cmp (
    .a   (rdata),
    .b   (key),
    .res (cmp)
  );

  // Bounds and end-of-walk tests.
  always_comb begin
    in_range = (32'(item.position) < 32'(len));
    j_last   = ((32'(j_idx) + 32'd1) == 32'(len));
    i_done   = ((32'(i_idx) + 32'd2) == 32'(len));
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      len   <= '0;
      clr   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
      clr   <= clr_next;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    i_idx    <= i_idx_next;
    j_idx    <= j_idx_next;
    pick     <= pick_next;
    key      <= key_next;
    head     <= head_next;
    r_status <= r_status_next;
    r_read   <= r_read_next;
    r_found  <= r_found_next;
  end

  // Next state and store port control.
  always_comb begin
    state_next    = state;
    len_next      = len;
    clr_next      = clr;
    i_idx_next    = i_idx;
    j_idx_next    = j_idx;
    pick_next     = pick;
    key_next      = key;
    head_next     = head;
    r_status_next = r_status;
    r_read_next   = r_read;
    r_found_next  = r_found;
    wr            = '0;
    raddr         = '0;
    in_ready      = 1'b0;
    res.vld                 = 1'b0;
    res.data.status         = r_status;
    res.data.read_value     = r_read;
    res.data.found_index    = r_found;
    res.data.current_length = CLEN_W'(len);

    unique case (state)
      // Zero the store once after reset, one word a cycle.
      S_CLEAR: begin
        wr.we    = 1'b1;
        wr.addr  = clr;
        clr_next = clr + 1'b1;
        if (clr == IDX_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      // Take one command and start it.
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          r_status_next = ST_OK;
          r_read_next   = '0;
          r_found_next  = '0;
          state_next    = S_RESULT;
          unique case (item.cmd)
            CMD_SET: begin
              if (in_range) begin
                wr.we   = 1'b1;
                wr.addr = item.position[IDX_W-1:0];
                wr.data = item.value;
              end else begin
                r_status_next = ST_BAD_INDEX;
              end
            end
            CMD_GET: begin
              if (in_range) begin
                raddr      = item.position[IDX_W-1:0];
                state_next = S_ACCESS;
              end else begin
                r_status_next = ST_BAD_INDEX;
              end
            end
            CMD_PUSH: begin
              if (len == LEN_W'(DEPTH)) begin
                r_status_next = ST_BAD_ALLOC;
              end else begin
                wr.we    = 1'b1;
                wr.addr  = len[IDX_W-1:0];
                wr.data  = item.value;
                len_next = len + 1'b1;
              end
            end
            CMD_POP: begin
              if (len == '0) begin
                r_status_next = ST_BAD_INDEX;
              end else begin
                len_next   = len - 1'b1;
                raddr      = IDX_W'(len - 1'b1);
                state_next = S_ACCESS;
              end
            end
            CMD_FIND: begin
              key_next = item.value;
              if (len == '0) begin
                r_status_next = ST_NOT_FOUND;
              end else begin
                raddr      = '0;
                j_idx_next = '0;
                state_next = S_FIND;
              end
            end
            CMD_SORT: begin
              if (32'(len) >= 32'd2) begin
                raddr      = '0;
                i_idx_next = '0;
                state_next = S_SORT_HEAD;
              end
            end
            CMD_RESIZE: begin
              if (32'(item.position) > 32'(DEPTH)) begin
                r_status_next = ST_BAD_ALLOC;
              end else begin
                len_next = LEN_W'(item.position);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Read data for get or pop has arrived.
      S_ACCESS: begin
        r_read_next = rdata;
        state_next  = S_RESULT;
      end

      // Linear search, one word compared per cycle, next read in flight.
      S_FIND: begin
        raddr = j_idx + 1'b1;
        if (cmp.eq) begin
          r_found_next = FIDX_W'(j_idx);
          state_next   = S_RESULT;
        end else if (j_last) begin
          r_status_next = ST_NOT_FOUND;
          state_next    = S_RESULT;
        end else begin
          j_idx_next = j_idx + 1'b1;
        end
      end

      // First word of a selection pass becomes the running minimum.
      S_SORT_HEAD: begin
        head_next  = rdata;
        key_next   = rdata;
        pick_next  = i_idx;
        j_idx_next = i_idx + 1'b1;
        raddr      = i_idx + 1'b1;
        state_next = S_SORT_SCAN;
      end

      // Scan the rest of the pass for a strictly smaller word.
      S_SORT_SCAN: begin
        if (cmp.lt) begin
          key_next  = rdata;
          pick_next = j_idx;
        end
        if (j_last) begin
          state_next = S_SWAP_A;
        end else begin
          raddr      = j_idx + 1'b1;
          j_idx_next = j_idx + 1'b1;
        end
      end

      // Old head goes to where the minimum was.
      S_SWAP_A: begin
        wr.we      = 1'b1;
        wr.addr    = pick;
        wr.data    = head;
        state_next = S_SWAP_B;
      end

      // Minimum goes to the head; start the next pass or finish.
      S_SWAP_B: begin
        wr.we      = 1'b1;
        wr.addr    = i_idx;
        wr.data    = key;
        i_idx_next = i_idx + 1'b1;
        if (i_done) begin
          state_next = S_RESULT;
        end else begin
          raddr      = i_idx + 1'b1;
          state_next = S_SORT_HEAD;
        end
      end

      // Hand the result over once the output register is free.
      S_RESULT: begin
        res.vld = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
